### rtl/skvt_pkg.sv
// Shared types, widths and operation codes of the key/value table.
package skvt_pkg;

   localparam int DEPTH       = 16;
   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int IDX_W       = $clog2(DEPTH);
   localparam int CNT_W       = $clog2(DEPTH + 1);
   localparam int CAP_W       = 5;
   localparam int OP_W        = 3;
   localparam int POS_W       = 4;
   localparam int COUNT_OUT_W = 5;

   localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
   localparam logic [OP_W-1:0] OP_UPDATE = 3'd1;
   localparam logic [OP_W-1:0] OP_UPSERT = 3'd2;
   localparam logic [OP_W-1:0] OP_ERASE  = 3'd3;
   localparam logic [OP_W-1:0] OP_LOOKUP = 3'd4;
   localparam logic [OP_W-1:0] OP_READ   = 3'd5;

   typedef struct packed {
      logic [OP_W-1:0]  opcode;
      logic [31:0]      key;
      logic [31:0]      value_in;
      logic [POS_W-1:0] index;
   } req_type;

   typedef struct packed {
      logic                   ok;
      logic [31:0]            key_out;
      logic [31:0]            value_out;
      logic [COUNT_OUT_W-1:0] entry_count;
      logic                   is_empty;
   } rsp_type;

   typedef struct packed {
      logic [KEY_WIDTH-1:0]   key;
      logic [VALUE_WIDTH-1:0] value;
   } entry_type;

endpackage

### rtl/skvt_req_if.sv
// Request channel: valid/ready handshake carrying one request item.
interface skvt_req_if;
   import skvt_pkg::*;
   logic    valid;
   logic    ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/skvt_rsp_if.sv
// Response channel: valid/ready handshake carrying one result item.
interface skvt_rsp_if;
   import skvt_pkg::*;
   logic    valid;
   logic    ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/skvt_csr_if.sv
// Configuration write channel: valid/ready handshake carrying the capacity.
interface skvt_csr_if;
   import skvt_pkg::*;
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;
   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/small_key_value_table.sv
// Top level of the bounded, densely packed key/value table.
//
//  channel | direction | payload                                   | handshake
//  req_ch  | in        | opcode, key, value_in, index              | valid/ready
//  rsp_ch  | out       | ok, key_out, value_out, entry_count, empty| valid/ready
//  csr_ch  | in        | capacity (5 bits)                         | valid/ready
//
// One item at a time. A key operation scans the packed entries and stops early
// when the key is found. An erase that moves the last entry into the hole
// also passes through the fetch state. read_index fetches the indexed entry
// unless the index is not below the count; an unknown opcode goes straight
// to the result. The scan reads one entry per cycle through the single read
// port of the entry memory.
// Reset clears the count, the sequencer and the output valid flag; capacity
// returns to 16. The entry memory is not cleared.
// A stalled result holds in the output register; the next item is taken
// while it waits, and its own result waits until the register frees.
module small_key_value_table (
   input  logic                 clock,
   input  logic                 reset,
   skvt_req_if.sink             req_ch,
   skvt_rsp_if.source           rsp_ch,
   skvt_csr_if.sink             csr_ch
);
   import skvt_pkg::*;

   // sequencer states
   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SCAN  = 3'd1;
   localparam logic [2:0] S_FETCH = 3'd2;
   localparam logic [2:0] S_RESP  = 3'd3;

   logic [2:0]             state_ff, state_in;
   logic [CAP_W-1:0]       capacity_ff;
   logic [CNT_W-1:0]       count_ff, count_in;

   // latched request
   req_type                req_ff, req_in;

   // scan control: scan_ff is the next address to read, chk_ff the address
   // whose data sits in the read register when pend_ff is set
   logic [CNT_W-1:0]       scan_ff, scan_in;
   logic [IDX_W-1:0]       chk_ff, chk_in;
   logic                   pend_ff, pend_in;
   logic [IDX_W-1:0]       pos_ff, pos_in;

   // pending result
   logic                   res_ok_ff, res_ok_in;
   logic [31:0]            res_key_ff, res_key_in;
   logic [31:0]            res_val_ff, res_val_in;

   // output register
   logic                   rsp_valid_ff;
   rsp_type                rsp_data_ff;

   // entry memory, one read and one write port
   entry_type              mem [DEPTH];
   entry_type              mem_rd_ff;
   logic [IDX_W-1:0]       rd_addr;
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   entry_type              wr_data;

   logic [CNT_W-1:0]       cap_eff;
   logic [CNT_W-1:0]       last_cnt;
   logic                   req_fire;
   logic                   rsp_free;
   logic                   hit;
   logic                   key_op;
   logic                   room;

   assign req_fire   = req_ch.valid && req_ch.ready;
   assign rsp_free   = !rsp_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == S_IDLE);
   assign csr_ch.ready = 1'b1;

   // clamp the capacity to the memory depth
   assign cap_eff  = (int'(capacity_ff) > DEPTH) ? CNT_W'(DEPTH) : CNT_W'(capacity_ff);
   assign last_cnt = count_ff - CNT_W'(1);
   assign room     = (count_ff < cap_eff);
   assign hit      = pend_ff && (mem_rd_ff.key == req_ff.key[KEY_WIDTH-1:0]);

   always_comb begin
      key_op = (req_ch.data.opcode == OP_INSERT) || (req_ch.data.opcode == OP_UPDATE) ||
               (req_ch.data.opcode == OP_UPSERT) || (req_ch.data.opcode == OP_ERASE) ||
               (req_ch.data.opcode == OP_LOOKUP);
   end

   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      req_in     = req_ff;
      scan_in    = scan_ff;
      chk_in     = chk_ff;
      pend_in    = 1'b0;
      pos_in     = pos_ff;
      res_ok_in  = res_ok_ff;
      res_key_in = res_key_ff;
      res_val_in = res_val_ff;
      rd_addr    = scan_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = chk_ff;
      wr_data    = '{key: req_ff.key[KEY_WIDTH-1:0], value: req_ff.value_in[VALUE_WIDTH-1:0]};

      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               req_in     = req_ch.data;
               res_ok_in  = 1'b0;
               res_key_in = '0;
               res_val_in = '0;
               scan_in    = '0;
               if (key_op) begin
                  state_in = S_SCAN;
               end else if (req_ch.data.opcode == OP_READ &&
                            CNT_W'(req_ch.data.index) < count_ff) begin
                  // issue the read of the indexed entry now
                  rd_addr  = req_ch.data.index[IDX_W-1:0];
                  state_in = S_FETCH;
               end else begin
                  state_in = S_RESP;
               end
            end
         end

         S_SCAN: begin
            if (hit) begin
               pos_in = chk_ff;
               case (req_ff.opcode)
                  OP_LOOKUP: begin
                     res_ok_in  = 1'b1;
                     res_val_in = 32'(mem_rd_ff.value);
                     state_in   = S_RESP;
                  end
                  OP_UPDATE, OP_UPSERT: begin
                     wr_en     = 1'b1;
                     wr_addr   = chk_ff;
                     res_ok_in = 1'b1;
                     state_in  = S_RESP;
                  end
                  OP_ERASE: begin
                     if (chk_ff == last_cnt[IDX_W-1:0]) begin
                        count_in  = last_cnt;
                        res_ok_in = 1'b1;
                        state_in  = S_RESP;
                     end else begin
                        // fetch the last entry to fill the hole
                        rd_addr  = last_cnt[IDX_W-1:0];
                        state_in = S_FETCH;
                     end
                  end
                  default: begin
                     state_in = S_RESP;
                  end
               endcase
            end else if (scan_ff < count_ff) begin
               // advance the scan by one entry
               pend_in = 1'b1;
               chk_in  = scan_ff[IDX_W-1:0];
               scan_in = scan_ff + CNT_W'(1);
            end else begin
               // key absent: append for insert and insert_or_update if there is room
               if ((req_ff.opcode == OP_INSERT || req_ff.opcode == OP_UPSERT) && room) begin
                  wr_en     = 1'b1;
                  wr_addr   = count_ff[IDX_W-1:0];
                  count_in  = count_ff + CNT_W'(1);
                  res_ok_in = 1'b1;
               end
               state_in = S_RESP;
            end
         end

         S_FETCH: begin
            res_ok_in = 1'b1;
            if (req_ff.opcode == OP_ERASE) begin
               wr_en    = 1'b1;
               wr_addr  = pos_ff;
               wr_data  = mem_rd_ff;
               count_in = last_cnt;
            end else begin
               res_key_in = 32'(mem_rd_ff.key);
               res_val_in = 32'(mem_rd_ff.value);
            end
            state_in = S_RESP;
         end

         S_RESP: begin
            if (rsp_free) begin
               state_in = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         count_ff    <= '0;
         capacity_ff <= CAP_W'(DEPTH);
         pend_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         pend_ff  <= pend_in;
         if (csr_ch.valid && csr_ch.ready) begin
            capacity_ff <= csr_ch.data;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      req_ff     <= req_in;
      scan_ff    <= scan_in;
      chk_ff     <= chk_in;
      pos_ff     <= pos_in;
      res_ok_ff  <= res_ok_in;
      res_key_ff <= res_key_in;
      res_val_ff <= res_val_in;
   end

   // entry memory
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      mem_rd_ff <= mem[rd_addr];
   end

   // output register: load the finished result when the slot frees
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (state_ff == S_RESP && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_RESP && rsp_free) begin
         rsp_data_ff.ok          <= res_ok_ff;
         rsp_data_ff.key_out     <= res_key_ff;
         rsp_data_ff.value_out   <= res_val_ff;
         rsp_data_ff.entry_count <= COUNT_OUT_W'(count_ff);
         rsp_data_ff.is_empty    <= (count_ff == '0);
      end
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_data_ff;

endmodule

### verif/skvt_result_checker.sv
`timescale 1ns / 1ps
// Result checker for the key/value table: tracks the table and compares every result.
module skvt_result_checker
   import skvt_pkg::*;
(
   input  logic clock,
   input  logic reset,
   skvt_req_if  req_ch,
   skvt_rsp_if  rsp_ch,
   skvt_csr_if  csr_ch,
   output int   mismatch_total,
   output int   open_count,
   output int   checked_total
);

   localparam int PRINT_LIMIT = 40;

   logic [KEY_WIDTH-1:0]   key_mem [DEPTH];
   logic [VALUE_WIDTH-1:0] val_mem [DEPTH];
   int                     live;
   logic [CAP_W-1:0]       cap_reg;
   rsp_type                expected_q[$];
   int                     errors;
   int                     checked;

   function automatic int find_slot(logic [KEY_WIDTH-1:0] k);
      for (int i = 0; i < live; i++) begin
         if (key_mem[IDX_W'(i)] == k) return i;
      end
      return -1;
   endfunction

   // Append at the end of the packed region; capacity above DEPTH acts as DEPTH.
   function automatic logic try_append(logic [KEY_WIDTH-1:0] k, logic [VALUE_WIDTH-1:0] v);
      int room;
      room = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
      if (live >= room || find_slot(k) >= 0) return 1'b0;
      key_mem[IDX_W'(live)] = k;
      val_mem[IDX_W'(live)] = v;
      live++;
      return 1'b1;
   endfunction

   function automatic rsp_type apply_request(req_type r);
      rsp_type res;
      int      slot;
      res  = '0;
      slot = find_slot(r.key);
      case (r.opcode)
         OP_INSERT: res.ok = try_append(r.key, r.value_in);
         OP_UPDATE: begin
            if (slot >= 0) begin
               val_mem[IDX_W'(slot)] = r.value_in;
               res.ok = 1'b1;
            end
         end
         OP_UPSERT: begin
            if (slot >= 0) begin
               val_mem[IDX_W'(slot)] = r.value_in;
               res.ok = 1'b1;
            end else begin
               res.ok = try_append(r.key, r.value_in);
            end
         end
         OP_ERASE: begin
            if (slot >= 0) begin
               key_mem[IDX_W'(slot)] = key_mem[IDX_W'(live-1)];
               val_mem[IDX_W'(slot)] = val_mem[IDX_W'(live-1)];
               live--;
               res.ok = 1'b1;
            end
         end
         OP_LOOKUP: begin
            if (slot >= 0) begin
               res.ok        = 1'b1;
               res.value_out = val_mem[IDX_W'(slot)];
            end
         end
         OP_READ: begin
            if (int'(r.index) < live) begin
               res.ok        = 1'b1;
               res.key_out   = key_mem[r.index];
               res.value_out = val_mem[r.index];
            end
         end
         default: ;
      endcase
      res.entry_count = COUNT_OUT_W'(live);
      res.is_empty    = (live == 0);
      return res;
   endfunction

   task automatic report_mismatch(string field, logic [31:0] got, logic [31:0] want);
      errors++;
      if (errors <= PRINT_LIMIT)
         $display("%0t: result %0d %s: got %h, expected %h", $time, checked, field, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         live    = 0;
         cap_reg = CAP_W'(DEPTH);
         expected_q.delete();
         errors  = 0;
         checked = 0;
      end else begin
         if (csr_ch.valid && csr_ch.ready) cap_reg = csr_ch.data;
         // Compare before pushing: a result never belongs to an item taken at the same edge.
         if (rsp_ch.valid && rsp_ch.ready) begin
            if (expected_q.size() == 0) begin
               report_mismatch("unexpected item", rsp_ch.data.value_out, '0);
            end else begin
               want = expected_q.pop_front();
               if (rsp_ch.data.ok !== want.ok)
                  report_mismatch("ok", 32'(rsp_ch.data.ok), 32'(want.ok));
               if (rsp_ch.data.key_out !== want.key_out)
                  report_mismatch("key_out", rsp_ch.data.key_out, want.key_out);
               if (rsp_ch.data.value_out !== want.value_out)
                  report_mismatch("value_out", rsp_ch.data.value_out, want.value_out);
               if (rsp_ch.data.entry_count !== want.entry_count)
                  report_mismatch("entry_count", 32'(rsp_ch.data.entry_count),
                                  32'(want.entry_count));
               if (rsp_ch.data.is_empty !== want.is_empty)
                  report_mismatch("is_empty", 32'(rsp_ch.data.is_empty), 32'(want.is_empty));
               checked++;
            end
         end
         if (req_ch.valid && req_ch.ready) expected_q.push_back(apply_request(req_ch.data));
      end
      mismatch_total <= errors;
      open_count     <= expected_q.size();
      checked_total  <= checked;
   end

endmodule

### verif/small_key_value_table_tb.sv
`timescale 1ns / 1ps
// Testbench top for the key/value table: clock, reset, stimulus, idling and verdict.
module small_key_value_table_tb;
   import skvt_pkg::*;

   // Opcodes the block must treat as no-ops.
   localparam logic [OP_W-1:0] OP_BAD_LO = 3'd6;
   localparam logic [OP_W-1:0] OP_BAD_HI = 3'd7;

   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 10;
   localparam int QUIET_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 30;
   localparam int POOL_SIZE     = 32;
   localparam int POOL_W        = $clog2(POOL_SIZE);

   localparam logic [31:0] KEY_A = 32'h5A5A_A5A5;
   localparam logic [31:0] KEY_B = 32'h0000_0001;
   localparam logic [31:0] KEY_C = 32'h8000_0000;

   logic        clock;
   logic        reset;
   int          mismatch_total;
   int          open_count;
   int          checked_total;
   int          send_idle_pct;
   int          recv_stall_pct;
   int          items_sent;
   int          cap_writes;
   int          quiet_cycles;
   logic [31:0] key_pool [POOL_SIZE];

   skvt_req_if req_if ();
   skvt_rsp_if rsp_if ();
   skvt_csr_if csr_if ();

   small_key_value_table u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if),
      .csr_ch (csr_if)
   );

   skvt_result_checker u_result_check (
      .clock          (clock),
      .reset          (reset),
      .req_ch         (req_if),
      .rsp_ch         (rsp_if),
      .csr_ch         (csr_if),
      .mismatch_total (mismatch_total),
      .open_count     (open_count),
      .checked_total  (checked_total)
   );

   always #(HALF_PERIOD) clock = ~clock;

   // Result side: drop ready at random according to the current stall rate.
   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Watchdog: end the run if no channel moves an item for too long.
   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
          || (csr_if.valid && csr_if.ready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type pack_request(logic [OP_W-1:0] op, logic [31:0] k,
                                            logic [31:0] v, logic [POS_W-1:0] idx);
      req_type r;
      r.opcode   = op;
      r.key      = k;
      r.value_in = v;
      r.index    = idx;
      return r;
   endfunction

   // Mostly keys from a small pool so that hits, duplicates and erases are common;
   // shrink leans on erase to drain the table toward empty.
   function automatic req_type random_request(int pool_len, bit shrink);
      req_type r;
      int      roll;
      roll = $urandom_range(99);
      if (roll < 3)
         r.opcode = ($urandom_range(1) != 0) ? OP_BAD_HI : OP_BAD_LO;
      else if (roll < (shrink ? 13 : 33))
         r.opcode = OP_INSERT;
      else if (roll < (shrink ? 21 : 48))
         r.opcode = OP_UPSERT;
      else if (roll < (shrink ? 31 : 58))
         r.opcode = OP_UPDATE;
      else if (roll < (shrink ? 71 : 70))
         r.opcode = OP_ERASE;
      else if (roll < 85)
         r.opcode = OP_LOOKUP;
      else
         r.opcode = OP_READ;
      if ($urandom_range(99) < 85)
         r.key = key_pool[POOL_W'($urandom_range(pool_len - 1))];
      else
         r.key = $urandom;
      r.value_in = $urandom;
      // Favor low positions, which are live far more often.
      r.index = ($urandom_range(99) < 60) ? POS_W'($urandom_range(3))
                                          : POS_W'($urandom_range(15));
      return r;
   endfunction

   // Hold the item until the block takes it; idle beforehand at the sender's rate.
   task automatic send_request(input req_type r);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.data  <= r;
      do @(posedge clock); while (!req_if.ready);
      items_sent++;
   endtask

   // Drop valid and wait until every expected result has come back.
   task automatic wait_drained();
      req_if.valid <= 1'b0;
      do @(posedge clock); while (open_count != 0);
   endtask

   task automatic write_capacity(input logic [CAP_W-1:0] cap);
      csr_if.valid <= 1'b1;
      csr_if.data  <= cap;
      do @(posedge clock); while (!csr_if.ready);
      csr_if.valid <= 1'b0;
      cap_writes++;
   endtask

   task automatic run_phase(input logic [CAP_W-1:0] cap, input int idle, input int stall,
                            input int count, input int pool_len, input bit shrink);
      wait_drained();
      send_idle_pct  = idle;
      recv_stall_pct = stall;
      write_capacity(cap);
      repeat (count) send_request(random_request(pool_len, shrink));
   endtask

   initial begin
      clock          = 1'b0;
      reset          = 1'b1;
      req_if.valid   = 1'b0;
      req_if.data    = '0;
      csr_if.valid   = 1'b0;
      csr_if.data    = '0;
      send_idle_pct  = 0;
      recv_stall_pct = 0;
      items_sent     = 0;
      cap_writes     = 0;

      // Key pool: both extremes, random words, and near misses one bit off a neighbor.
      key_pool[0] = '0;
      key_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) begin
         if (i % 4 == 3)
            key_pool[POOL_W'(i)] = key_pool[POOL_W'(i-1)] ^ (32'd1 << $urandom_range(31));
         else
            key_pool[POOL_W'(i)] = $urandom;
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed part at the reset capacity: empty-table misses and no-op codes first.
      send_request(pack_request(OP_LOOKUP, '0, $urandom, '0));
      send_request(pack_request(OP_READ, $urandom, $urandom, '0));
      send_request(pack_request(OP_ERASE, '1, $urandom, '0));
      send_request(pack_request(OP_UPDATE, '0, '1, '0));
      send_request(pack_request(OP_BAD_LO, '1, '1, '1));
      send_request(pack_request(OP_BAD_HI, '0, '0, '0));
      // Fill with extreme keys and values, then a duplicate insert.
      send_request(pack_request(OP_INSERT, '0, '1, '0));
      send_request(pack_request(OP_INSERT, '1, '0, '1));
      send_request(pack_request(OP_INSERT, '0, 32'd1, '0));
      // Insert-or-update down both paths, then a plain update and lookup.
      send_request(pack_request(OP_UPSERT, '0, 32'h1234_5678, '0));
      send_request(pack_request(OP_UPSERT, KEY_A, 32'h8765_4321, '0));
      send_request(pack_request(OP_UPDATE, '1, 32'hA5A5_5A5A, '0));
      send_request(pack_request(OP_LOOKUP, '1, '0, '0));
      // Read by position: last live entry, at the count, and the top position.
      send_request(pack_request(OP_READ, '0, '0, 4'd2));
      send_request(pack_request(OP_READ, '0, '0, 4'd3));
      send_request(pack_request(OP_READ, '0, '0, '1));
      // Erase the first entry so the last one fills the hole, then the last entry.
      send_request(pack_request(OP_ERASE, '0, '0, '0));
      send_request(pack_request(OP_READ, '0, '0, '0));
      send_request(pack_request(OP_ERASE, '1, '0, '0));
      send_request(pack_request(OP_LOOKUP, KEY_A, '0, '0));

      // Table now holds one entry: a capacity of two fills after one insert.
      wait_drained();
      write_capacity(CAP_W'(2));
      send_request(pack_request(OP_INSERT, KEY_B, 32'hDEAD_BEEF, '0));
      send_request(pack_request(OP_INSERT, KEY_C, 32'h0BAD_F00D, '0));
      send_request(pack_request(OP_UPSERT, KEY_C, 32'h0BAD_F00D, '0));

      // Lower capacity below the count: nothing is dropped, inserts fail.
      wait_drained();
      write_capacity(CAP_W'(1));
      send_request(pack_request(OP_LOOKUP, KEY_B, '0, '0));
      send_request(pack_request(OP_INSERT, KEY_C, '1, '0));

      // Random phases: capacity, sender idle %, receiver stall %, items, pool, shrink.
      run_phase(CAP_W'(16), 0,  0,  150, 24, 1'b0);
      run_phase('1,         56, 0,  150, 32, 1'b0);
      run_phase(CAP_W'(4),  0,  56, 150, 12, 1'b0);
      run_phase('0,         21, 21, 100, 12, 1'b1);
      run_phase(CAP_W'(1),  56, 0,  120, 6,  1'b0);
      run_phase(CAP_W'(17), 0,  56, 150, 20, 1'b1);
      run_phase(CAP_W'(9),  21, 21, 150, 16, 1'b0);

      // Drain, then idle for SETTLE_CYCLES so any stray result can show up.
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d request items and %0d checked results over %0d capacity writes,",
               items_sent, checked_total, cap_writes);
      $display("with no idling, sender gaps, result stalls and both; %0d mismatches.",
               mismatch_total);
      if (mismatch_total == 0 && open_count == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

### sim.f
rtl/skvt_pkg.sv
rtl/skvt_req_if.sv
rtl/skvt_rsp_if.sv
rtl/skvt_csr_if.sv
rtl/small_key_value_table.sv
verif/skvt_result_checker.sv
verif/small_key_value_table_tb.sv
